FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is high
`define FDPT_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion that also holds across reset
`define FDPT_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: src/fdpt_pkg.sv
package fdpt_pkg;

  localparam int MAX_YEAR = 9999;
  localparam int YEAR_W = 14;
  localparam int DN_W = 22;
  localparam int SUM_W = DN_W + 2;
  localparam int QUO_W = 8;
  localparam int DIV100_MUL = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [YEAR_W-1:0] YEAR_CLAMP = YEAR_W'(MAX_YEAR);
  localparam logic [DN_W-1:0] DN_MAX = {DN_W{1'b1}};

  typedef struct packed {
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
    logic              last;
  } date_t;

  typedef struct packed {
    logic [4:0]        first_day;
    logic [3:0]        first_month;
    logic [YEAR_W-1:0] first_year;
    logic [4:0]        second_day;
    logic [3:0]        second_month;
    logic [YEAR_W-1:0] second_year;
    logic [DN_W-1:0]   distance;
    logic              enough_dates;
  } pair_t;

  typedef struct packed {
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
  } cal_t;

  typedef struct packed {
    cal_t            cal;
    logic            last;
    logic [DN_W-1:0] dn;
  } item_t;

  // days of the months before the given one, common year
  function automatic logic [8:0] cum_days(input logic [3:0] month);
    logic [8:0] days;
    case (month)
      4'd0, 4'd1: days = 9'd0;
      4'd2:  days = 9'd31;
      4'd3:  days = 9'd59;
      4'd4:  days = 9'd90;
      4'd5:  days = 9'd120;
      4'd6:  days = 9'd151;
      4'd7:  days = 9'd181;
      4'd8:  days = 9'd212;
      4'd9:  days = 9'd243;
      4'd10: days = 9'd273;
      4'd11: days = 9'd304;
      4'd12: days = 9'd334;
      default: days = 9'd365;
    endcase
    return days;
  endfunction

endpackage

FILE: src/farthest_date_pair_tracker.sv
// farthest date pair tracker
// date channel: date_valid / date_ready with a date_t payload (day, month,
//   year, last); a transaction is taken when both are high
// pair channel: pair_valid / pair_ready with a pair_t payload; one
//   transaction follows each date marked last, giving the earliest and the
//   latest date of the set in arrival order and their distance in days
// throughput: one date per cycle while date_ready stays high
// path: the last date passes the front stage with the year multiply, then
//   the queue, then the tracker, whose result register raises pair_valid
// the front computes day numbers, a 4-entry queue decouples it from the
//   tracker; when the receiver holds pair_ready low, dates still flow into
//   the tracker until another last date needs the result register, then
//   the queue fills and date_ready drops
// reset (rst, synchronous) empties the pipeline and the queue, drops
//   pair_valid and starts a new set
module farthest_date_pair_tracker (
  input  logic            clk,
  input  logic            rst,
  input  logic            date_valid,
  output logic            date_ready,
  input  fdpt_pkg::date_t date,
  output logic            pair_valid,
  input  logic            pair_ready,
  output fdpt_pkg::pair_t pair
);

  logic            fq_valid;
  logic            fq_ready;
  fdpt_pkg::item_t fq_item;
  logic            qb_valid;
  logic            qb_ready;
  fdpt_pkg::item_t qb_item;

  fdpt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .date_valid (date_valid),
    .date_ready (date_ready),
    .date       (date),
    .item_valid (fq_valid),
    .item_ready (fq_ready),
    .item       (fq_item)
  );

  fdpt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  fdpt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (qb_valid),
    .item_ready (qb_ready),
    .item       (qb_item),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .pair       (pair)
  );

endmodule

FILE: src/fdpt_front.sv
module fdpt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            date_valid,
  output logic            date_ready,
  input  fdpt_pkg::date_t date,
  output logic            item_valid,
  input  logic            item_ready,
  output fdpt_pkg::item_t item
);

  localparam int PROD_W = fdpt_pkg::YEAR_W + 14;

  logic [fdpt_pkg::YEAR_W-1:0] y_clamp;
  logic [fdpt_pkg::YEAR_W-1:0] y_before;
  logic [PROD_W-1:0]           prod_b;
  logic [PROD_W-1:0]           prod_y;
  logic [fdpt_pkg::DN_W:0]     yb365_next;

  logic                        s1_valid;
  fdpt_pkg::date_t             s1_date;
  logic [fdpt_pkg::YEAR_W-1:0] s1_y;
  logic [fdpt_pkg::YEAR_W-1:0] s1_yb;
  logic [fdpt_pkg::DN_W:0]     s1_yb365;
  logic [fdpt_pkg::QUO_W-1:0]  s1_qb;
  logic [fdpt_pkg::QUO_W-1:0]  s1_qy;

  logic                        y100_zero;
  logic                        leap;
  logic                        leap_adj;
  logic [fdpt_pkg::SUM_W-1:0]  dn_sum;

  // stage one: clamp, year multiply and reciprocal divides by 100
  always_comb begin
    y_clamp = (date.year > fdpt_pkg::YEAR_CLAMP) ? fdpt_pkg::YEAR_CLAMP : date.year;
    y_before = (y_clamp != '0) ? y_clamp - 1'b1 : '0;
    prod_b = PROD_W'(y_before) * PROD_W'(fdpt_pkg::DIV100_MUL);
    prod_y = PROD_W'(y_clamp) * PROD_W'(fdpt_pkg::DIV100_MUL);
    yb365_next = (fdpt_pkg::DN_W + 1)'(y_before) * (fdpt_pkg::DN_W + 1)'(365);
  end

  assign date_ready = !s1_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (date_ready) begin
      s1_valid <= date_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (date_valid && date_ready) begin
      s1_date  <= date;
      s1_y     <= y_clamp;
      s1_yb    <= y_before;
      s1_yb365 <= yb365_next;
      s1_qb    <= prod_b[fdpt_pkg::DIV100_SHIFT +: fdpt_pkg::QUO_W];
      s1_qy    <= prod_y[fdpt_pkg::DIV100_SHIFT +: fdpt_pkg::QUO_W];
    end
  end

  // stage two: leap rule and day number sum
  always_comb begin
    y100_zero = (s1_y == fdpt_pkg::YEAR_W'(fdpt_pkg::YEAR_W'(s1_qy) * fdpt_pkg::YEAR_W'(100)));
    leap = ((s1_y[1:0] == 2'b00) && !y100_zero) || (y100_zero && (s1_qy[1:0] == 2'b00));
    leap_adj = leap && (s1_date.month >= 4'd3);
    dn_sum = fdpt_pkg::SUM_W'(s1_yb365)
           + fdpt_pkg::SUM_W'(s1_yb[fdpt_pkg::YEAR_W-1:2])
           + fdpt_pkg::SUM_W'(s1_qb[fdpt_pkg::QUO_W-1:2])
           + fdpt_pkg::SUM_W'(fdpt_pkg::cum_days(s1_date.month))
           + fdpt_pkg::SUM_W'(leap_adj)
           + fdpt_pkg::SUM_W'(s1_date.day)
           - fdpt_pkg::SUM_W'(s1_qb);
    item.cal.day   = s1_date.day;
    item.cal.month = s1_date.month;
    item.cal.year  = s1_date.year;
    item.last      = s1_date.last;
    item.dn        = (dn_sum > fdpt_pkg::SUM_W'(fdpt_pkg::DN_MAX)) ? fdpt_pkg::DN_MAX
                                                                   : dn_sum[fdpt_pkg::DN_W-1:0];
  end

  assign item_valid = s1_valid;

endmodule

FILE: src/fdpt_queue.sv
module fdpt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  fdpt_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output fdpt_pkg::item_t pop_item
);

  fdpt_pkg::item_t             mem [fdpt_pkg::QUEUE_DEPTH];
  logic [fdpt_pkg::QPTR_W-1:0] wr_ptr;
  logic [fdpt_pkg::QPTR_W-1:0] rd_ptr;
  logic [fdpt_pkg::QCNT_W-1:0] count;
  logic                        push;
  logic                        pop;

  assign push_ready = (count != fdpt_pkg::QCNT_W'(fdpt_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == fdpt_pkg::QPTR_W'(fdpt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == fdpt_pkg::QPTR_W'(fdpt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: src/fdpt_back.sv
module fdpt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  fdpt_pkg::item_t item,
  output logic            pair_valid,
  input  logic            pair_ready,
  output fdpt_pkg::pair_t pair
);

  logic [fdpt_pkg::DN_W-1:0] min_day_number;
  logic [fdpt_pkg::DN_W-1:0] max_day_number;
  fdpt_pkg::cal_t            min_date;
  fdpt_pkg::cal_t            max_date;
  logic                      min_arrived_first;
  logic [1:0]                seen_count;

  logic [fdpt_pkg::DN_W-1:0] min_day_number_next;
  logic [fdpt_pkg::DN_W-1:0] max_day_number_next;
  fdpt_pkg::cal_t            min_date_next;
  fdpt_pkg::cal_t            max_date_next;
  logic                      min_arrived_first_next;
  logic [1:0]                seen_count_next;
  fdpt_pkg::cal_t            early;
  fdpt_pkg::cal_t            late;
  fdpt_pkg::pair_t           pair_next;
  logic                      take;
  logic                      opening;
  logic                      lower;
  logic                      higher;

  assign item_ready = !item.last || !pair_valid || pair_ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    opening = (seen_count == 2'd0);
    lower   = item.dn < min_day_number;
    higher  = item.dn > max_day_number;

    min_day_number_next    = min_day_number;
    max_day_number_next    = max_day_number;
    min_date_next          = min_date;
    max_date_next          = max_date;
    min_arrived_first_next = min_arrived_first;
    if (opening || lower) begin
      min_day_number_next    = item.dn;
      min_date_next          = item.cal;
      min_arrived_first_next = opening;
    end
    if (opening || higher) begin
      max_day_number_next    = item.dn;
      max_date_next          = item.cal;
      min_arrived_first_next = 1'b1;
    end
    seen_count_next = (seen_count == 2'd2) ? 2'd2 : seen_count + 1'b1;

    early = min_arrived_first_next ? min_date_next : max_date_next;
    late  = min_arrived_first_next ? max_date_next : min_date_next;
    pair_next = '0;
    if (seen_count_next == 2'd2) begin
      pair_next.first_day    = early.day;
      pair_next.first_month  = early.month;
      pair_next.first_year   = early.year;
      pair_next.second_day   = late.day;
      pair_next.second_month = late.month;
      pair_next.second_year  = late.year;
      pair_next.distance     = max_day_number_next - min_day_number_next;
      pair_next.enough_dates = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count        <= 2'd0;
      min_arrived_first <= 1'b0;
      pair_valid        <= 1'b0;
    end else begin
      if (take) begin
        seen_count        <= item.last ? 2'd0 : seen_count_next;
        min_arrived_first <= min_arrived_first_next;
      end
      if (take && item.last) begin
        pair_valid <= 1'b1;
      end else if (pair_ready) begin
        pair_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      min_day_number <= min_day_number_next;
      max_day_number <= max_day_number_next;
      min_date       <= min_date_next;
      max_date       <= max_date_next;
    end
    if (take && item.last) begin
      pair <= pair_next;
    end
  end

endmodule

FILE: src/fdpt_checker.sv
`include "assert_macros.svh"

module fdpt_checker (
  input logic            clk,
  input logic            rst,
  input logic            pair_valid,
  input logic            pair_ready,
  input fdpt_pkg::pair_t pair
);

  logic short_set_zero;
  logic same_dates;

  assign short_set_zero = (pair.distance == '0) && (pair.first_year == '0)
                        && (pair.second_year == '0);
  assign same_dates = (pair.first_day == pair.second_day)
                    && (pair.first_month == pair.second_month)
                    && (pair.first_year == pair.second_year);

  `FDPT_ASSERT_RST(a_reset_drops_pair, rst |=> !pair_valid)
  `FDPT_ASSERT(a_pair_holds, pair_valid && !pair_ready |=> pair_valid && $stable(pair))
  `FDPT_ASSERT(a_short_set_zero, pair_valid && !pair.enough_dates |-> short_set_zero)
  `FDPT_ASSERT(a_same_date_no_gap, pair_valid && same_dates |-> pair.distance == '0)

endmodule

bind farthest_date_pair_tracker fdpt_checker u_fdpt_checker (.*);

FILE: tb/sv/farthest_date_pair_tracker_tb.sv
`timescale 1ns / 1ps

module farthest_date_pair_tracker_tb;
  import fdpt_pkg::*;

  localparam int STIM_ITEMS = 1650;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int EDGE_YEARS [13] = '{1, 4, 100, 400, 1500, 1900, 2000, 2024, 2100,
                                     8191, 8192, 9998, 9999};

  typedef struct packed {
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
  } ymd_t;

  typedef struct {
    date_t d;
    bit    known;
    pair_t p;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  date_valid = 1'b0;
  logic  date_ready;
  date_t date = '0;
  logic  pair_valid;
  logic  pair_ready = 1'b0;
  pair_t pair;

  stim_row_t stim[$];
  pair_t     pending_pairs[$];
  int        errors = 0;
  int        cycles = 0;
  int        taken_count = 0;
  int        send_idx = 0;
  int        gap_left = 0;
  int        burst_left = 0;
  int        recv_mode = 0;
  logic      hold_off = 1'b0;
  int        hold_left = 0;
  int        holds_done = 0;

  // running min / max of the open date set
  logic [DN_W-1:0] lo_dn, hi_dn;
  ymd_t            lo_date, hi_date;
  bit              lo_first;
  int              seen;

  farthest_date_pair_tracker dut (
    .clk        (clk),
    .rst        (rst),
    .date_valid (date_valid),
    .date_ready (date_ready),
    .date       (date),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .pair       (pair)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned day_count(logic [4:0] day, logic [3:0] month,
                                            logic [YEAR_W-1:0] year);
    int unsigned y, yb, n, mcount;
    bit leap;
    y = (year > MAX_YEAR) ? MAX_YEAR : year;
    yb = (y > 0) ? y - 1 : 0;
    n = yb * 365 + yb / 4 - yb / 100 + yb / 400;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    mcount = (month > 0) ? month - 1 : 0;
    if (mcount > 12) mcount = 12;
    for (int m = 0; m < mcount; m++) begin
      n += MONTH_DAYS[m];
      if (m == 1 && leap) n += 1;
    end
    n += day;
    if (n > DN_MAX) n = DN_MAX;
    return n;
  endfunction

  function automatic bit track_date(date_t d, output pair_t res);
    logic [DN_W-1:0] dn;
    ymd_t cur, a, b;
    dn = DN_W'(day_count(d.day, d.month, d.year));
    cur = {d.day, d.month, d.year};
    res = '0;
    if (seen == 0) begin
      lo_dn = dn;
      hi_dn = dn;
      lo_date = cur;
      hi_date = cur;
      lo_first = 1'b1;
    end else begin
      if (dn < lo_dn) begin
        lo_dn = dn;
        lo_date = cur;
        lo_first = 1'b0;
      end
      if (dn > hi_dn) begin
        hi_dn = dn;
        hi_date = cur;
        lo_first = 1'b1;
      end
    end
    if (seen < 2) seen++;
    if (!d.last) return 1'b0;
    if (seen >= 2) begin
      a = lo_first ? lo_date : hi_date;
      b = lo_first ? hi_date : lo_date;
      res = {a.day, a.month, a.year, b.day, b.month, b.year, hi_dn - lo_dn, 1'b1};
    end
    seen = 0;
    return 1'b1;
  endfunction

  function automatic date_t rand_date();
    date_t d;
    int sel;
    sel = $urandom_range(0, 9);
    d.day = 5'($urandom_range(1, 31));
    d.month = 4'($urandom_range(1, 12));
    d.year = YEAR_W'($urandom_range(1, MAX_YEAR));
    d.last = 1'b0;
    if (sel == 0) begin
      d.day = 5'($urandom);
      d.month = 4'($urandom);
      d.year = YEAR_W'($urandom);
    end else if (sel == 1) begin
      d.year = YEAR_W'(EDGE_YEARS[$urandom_range(0, 12)]);
      d.month = 4'($urandom_range(2, 3));
    end
    return d;
  endfunction

  task automatic add(int dd, int mm, int yy, bit ll, bit known = 1'b0, pair_t p = '0);
    stim_row_t r;
    r.d = {5'(dd), 4'(mm), 14'(yy), ll};
    r.known = known;
    r.p = p;
    stim.push_back(r);
  endtask

  task automatic report(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic check_pair(pair_t got, pair_t want);
    cmp_field("first_day", got.first_day, want.first_day);
    cmp_field("first_month", got.first_month, want.first_month);
    cmp_field("first_year", got.first_year, want.first_year);
    cmp_field("second_day", got.second_day, want.second_day);
    cmp_field("second_month", got.second_month, want.second_month);
    cmp_field("second_year", got.second_year, want.second_year);
    cmp_field("distance", got.distance, want.distance);
    cmp_field("enough_dates", got.enough_dates, want.enough_dates);
  endtask

  // sender: bursts with random gaps, no gaps while the receiver is held off
  always @(posedge clk) begin
    if (rst) begin
      date_valid <= 1'b0;
      send_idx = 0;
      gap_left = 0;
      burst_left = 0;
    end else if (!date_valid || date_ready) begin
      if (send_idx < stim.size() && (gap_left == 0 || hold_off)) begin
        date_valid <= 1'b1;
        date <= stim[send_idx].d;
        send_idx++;
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(30, 60);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(0, 11);
          gap_left = $urandom_range(1, 8);
        end
      end else begin
        date_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // receiver stall pattern, drawn at random from four modes
  always @(posedge clk) begin : recv_proc
    logic rdy;
    if (cycles % 128 == 0) recv_mode = $urandom_range(0, 3);
    case (recv_mode)
      0: rdy = 1'b1;
      1: rdy = 1'($urandom_range(0, 1));
      2: rdy = ($urandom_range(0, 3) == 0);
      default: rdy = cycles[2];
    endcase
    if (rst) pair_ready <= 1'b0;
    else pair_ready <= rdy && !hold_off;
  end

  // long receiver hold-off so the pipeline fills and date_ready drops
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 1'b0;
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      hold_off <= (hold_left != 1);
    end else if (holds_done < 2 && taken_count >= 400 + 700 * holds_done) begin
      hold_left <= HOLD_CYCLES;
      hold_off <= 1'b1;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk) begin : check_proc
    pair_t guess, want;
    bit has;
    if (rst) begin
      seen = 0;
      lo_first = 1'b0;
      taken_count <= 0;
    end else begin
      if (date_valid && date_ready) begin
        has = track_date(date, guess);
        if (has) pending_pairs.push_back(stim[taken_count].known ? stim[taken_count].p : guess);
        taken_count <= taken_count + 1;
      end
      if (pair_valid && pair_ready) begin
        if (pending_pairs.size() == 0) begin
          report("pair transaction with nothing expected");
        end else begin
          want = pending_pairs.pop_front();
          check_pair(pair, want);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("farthest_date_pair_tracker_tb failed");
      $finish;
    end
  end

  initial begin : main_proc
    date_t d, prev;
    int set_len;
    // single date, set too short
    add(1, 1, 1, 1'b1, 1'b1, '0);
    // widest legal distance
    add(1, 1, 1, 1'b0);
    add(31, 12, 9999, 1'b1, 1'b1,
        {5'd1, 4'd1, 14'd1, 5'd31, 4'd12, 14'd9999, 22'd3652058, 1'b1});
    // all equal
    add(5, 5, 2000, 1'b0);
    add(5, 5, 2000, 1'b1, 1'b1,
        {5'd5, 4'd5, 14'd2000, 5'd5, 4'd5, 14'd2000, 22'd0, 1'b1});
    // leap boundaries
    add(1, 3, 2000, 1'b0);
    add(29, 2, 2000, 1'b1);
    add(28, 2, 1900, 1'b0);
    add(1, 3, 1900, 1'b1);
    // ties, min arriving after max
    add(1, 1, 2020, 1'b0);
    add(1, 1, 2030, 1'b0);
    add(1, 1, 2010, 1'b0);
    add(1, 1, 2030, 1'b0);
    add(1, 1, 2010, 1'b1);
    // month out of range
    add(10, 0, 2023, 1'b0);
    add(10, 15, 2023, 1'b0);
    add(10, 13, 2023, 1'b1);
    // zero fields and all-ones fields
    add(0, 0, 0, 1'b0);
    add(31, 15, 16383, 1'b1);
    add(1, 3, 0, 1'b0);
    add(1, 1, 1, 1'b1);
    add(31, 15, 16383, 1'b1, 1'b1, '0);

    prev = '0;
    while (stim.size() < STIM_ITEMS) begin
      set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
      for (int k = 0; k < set_len; k++) begin
        if (k > 0 && $urandom_range(0, 7) == 0) d = prev;
        else d = rand_date();
        d.last = (k == set_len - 1);
        add(d.day, d.month, d.year, d.last);
        prev = d;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (!(send_idx == stim.size() && !date_valid && pending_pairs.size() == 0))
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("farthest_date_pair_tracker_tb passed");
    end else begin
      $display("farthest_date_pair_tracker_tb failed");
    end
    $finish;
  end

endmodule
